// ===== hw/rtl/ssit_pkg.sv =====
// shared types and codes for the sorted sparse index table
package ssit_pkg;

  // request codes
  typedef enum logic [1:0] {
    OP_GET   = 2'd0,
    OP_SET   = 2'd1,
    OP_UNSET = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  localparam int unsigned DATA_OUT_W = 32;
  localparam int unsigned COUNT_OUT_W = 9;

  // one finished result beat, control to output stage
  typedef struct packed {
    status_t                  status;
    logic [DATA_OUT_W-1:0]    data_out;
    logic [COUNT_OUT_W-1:0]   entry_count;
  } res_t;

endpackage

// ===== hw/rtl/sorted_sparse_index_table_top.sv =====
// top level of the sorted sparse index table: sequencer, key and value rams, output register
//
// Keeps up to TABLE_DEPTH (index, value) pairs sorted by index in two one-port-write,
// one-port-read rams with a registered read. One request is worked on at a time; a
// clear goes straight to its result, any other request runs the binary search steps
// plus the probe, and an insert or remove then moves every later entry one place
// through the single ram write port, one entry per cycle. The output register lets a
// new request be taken while a result waits. The rams need no clearing pass: only
// entries below the stored count are used.
module sorted_sparse_index_table_top #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned INDEX_BITS  = 32,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_index,
  input  logic [31:0] in_data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_data_out,
  output logic [8:0]  out_entry_count
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic                  res_valid;
  logic                  res_ready;
  ssit_pkg::res_t        res;
  logic [AW-1:0]         mem_rd_addr;
  logic [AW-1:0]         mem_wr_addr;
  logic                  key_we;
  logic [INDEX_BITS-1:0] key_wdata;
  logic [INDEX_BITS-1:0] key_rdata;
  logic                  val_we;
  logic [VALUE_BITS-1:0] val_wdata;
  logic [VALUE_BITS-1:0] val_rdata;
  logic                  out_valid_r;
  ssit_pkg::res_t        out_res_r;

  ssit_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (INDEX_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_valid),
    .req_ready   (in_ready),
    .req_op      (in_op),
    .req_index   (in_index),
    .req_data    (in_data_in),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_rd_addr (mem_rd_addr),
    .mem_wr_addr (mem_wr_addr),
    .key_we      (key_we),
    .key_wdata   (key_wdata),
    .key_rdata   (key_rdata),
    .val_we      (val_we),
    .val_wdata   (val_wdata),
    .val_rdata   (val_rdata)
  );

  ssit_ram #(
    .WIDTH (INDEX_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (mem_wr_addr),
    .wr_data (key_wdata),
    .rd_addr (mem_rd_addr),
    .rd_data (key_rdata)
  );

  ssit_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (mem_wr_addr),
    .wr_data (val_wdata),
    .rd_addr (mem_rd_addr),
    .rd_data (val_rdata)
  );

  // output register takes a result when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_data_out    = out_res_r.data_out;
  assign out_entry_count = out_res_r.entry_count;

endmodule

// ===== hw/rtl/ssit_ram.sv =====
// generic simple dual port ram, one write port, one registered read port
module ssit_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/ssit_ctrl.sv =====
// request sequencer: binary search, probe, shift and insert over the key and value rams
module ssit_ctrl #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned INDEX_BITS  = 32,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request beat
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [1:0]                     req_op,
  input  logic [31:0]                    req_index,
  input  logic [31:0]                    req_data,
  // result to output stage
  output logic                           res_valid,
  input  logic                           res_ready,
  output ssit_pkg::res_t                 res,
  // memory ports
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_rd_addr,
  output logic [$clog2(TABLE_DEPTH)-1:0] mem_wr_addr,
  output logic                           key_we,
  output logic [INDEX_BITS-1:0]          key_wdata,
  input  logic [INDEX_BITS-1:0]          key_rdata,
  output logic                           val_we,
  output logic [VALUE_BITS-1:0]          val_wdata,
  input  logic [VALUE_BITS-1:0]          val_rdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRD,
    S_SCMP,
    S_PCHK,
    S_SHIFT,
    S_INS,
    S_FIN
  } state_t;

  state_t                      state_r;
  ssit_pkg::op_t               op_r;
  logic [INDEX_BITS-1:0]       key_r;
  logic [VALUE_BITS-1:0]       val_r;
  logic [CW-1:0]               count_r;
  logic [CW-1:0]               first_r;
  logic [CW-1:0]               span_r;
  logic [CW-1:0]               cur_r;
  logic                        pend_r;
  logic                        up_r;
  logic [AW-1:0]               wr_addr_r;
  ssit_pkg::status_t           st_r;
  logic [ssit_pkg::DATA_OUT_W-1:0] data_r;

  logic [CW-1:0] half;
  logic [CW-1:0] mid;
  logic          hit;
  logic          full;
  logic          more;

  // search and shift helpers
  assign half = span_r >> 1;
  assign mid  = first_r + half;
  assign hit  = (first_r < count_r) && (key_rdata == key_r);
  assign full = (count_r == CW'(TABLE_DEPTH));
  assign more = up_r ? (cur_r > first_r) : (cur_r < count_r);

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res.status      = st_r;
  assign res.data_out    = data_r;
  assign res.entry_count = ssit_pkg::COUNT_OUT_W'(count_r);

  // memory port drive
  always_comb begin
    mem_rd_addr = AW'(first_r);
    mem_wr_addr = AW'(first_r);
    key_we      = 1'b0;
    val_we      = 1'b0;
    key_wdata   = key_r;
    val_wdata   = val_r;
    unique case (state_r)
      S_SRD: begin
        mem_rd_addr = (span_r == '0) ? AW'(first_r) : AW'(mid);
      end
      S_PCHK: begin
        // overwrite of a present key
        val_we = (op_r == ssit_pkg::OP_SET) && hit;
      end
      S_SHIFT: begin
        mem_rd_addr = up_r ? AW'(cur_r - CW'(1)) : AW'(cur_r);
        mem_wr_addr = wr_addr_r;
        key_we      = pend_r;
        val_we      = pend_r;
        key_wdata   = key_rdata;
        val_wdata   = val_rdata;
      end
      S_INS: begin
        key_we = 1'b1;
        val_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            op_r    <= ssit_pkg::op_t'(req_op);
            key_r   <= INDEX_BITS'(req_index);
            val_r   <= VALUE_BITS'(req_data);
            first_r <= '0;
            span_r  <= count_r;
            data_r  <= '0;
            st_r    <= ssit_pkg::ST_OK;
            if (ssit_pkg::op_t'(req_op) == ssit_pkg::OP_CLEAR) begin
              count_r <= '0;
              state_r <= S_FIN;
            end else begin
              state_r <= S_SRD;
            end
          end
        end
        S_SRD: begin
          // span zero means first_r is the lower bound, its read is the probe
          state_r <= (span_r == '0) ? S_PCHK : S_SCMP;
        end
        S_SCMP: begin
          if (key_rdata < key_r) begin
            first_r <= mid + CW'(1);
            span_r  <= span_r - half - CW'(1);
          end else begin
            span_r <= half;
          end
          state_r <= S_SRD;
        end
        S_PCHK: begin
          state_r <= S_FIN;
          pend_r  <= 1'b0;
          unique case (op_r)
            ssit_pkg::OP_GET: begin
              if (hit) begin
                data_r <= ssit_pkg::DATA_OUT_W'(val_rdata);
              end else begin
                st_r <= ssit_pkg::ST_ABSENT;
              end
            end
            ssit_pkg::OP_SET: begin
              if (!hit) begin
                if (full) begin
                  st_r <= ssit_pkg::ST_FULL;
                end else begin
                  cur_r   <= count_r;
                  up_r    <= 1'b1;
                  state_r <= S_SHIFT;
                end
              end
            end
            ssit_pkg::OP_UNSET: begin
              if (hit) begin
                cur_r   <= first_r + CW'(1);
                up_r    <= 1'b0;
                state_r <= S_SHIFT;
              end else begin
                st_r <= ssit_pkg::ST_ABSENT;
              end
            end
            ssit_pkg::OP_CLEAR: begin
            end
            default: begin
            end
          endcase
        end
        S_SHIFT: begin
          // read one entry ahead, write the one read last cycle
          if (more) begin
            pend_r    <= 1'b1;
            wr_addr_r <= up_r ? AW'(cur_r) : AW'(cur_r - CW'(1));
            cur_r     <= up_r ? (cur_r - CW'(1)) : (cur_r + CW'(1));
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              if (up_r) begin
                state_r <= S_INS;
              end else begin
                count_r <= count_r - CW'(1);
                state_r <= S_FIN;
              end
            end
          end
        end
        S_INS: begin
          count_r <= count_r + CW'(1);
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ssit_chk.sv =====
// port level checks for the sorted sparse index table, bound to the top level
module ssit_chk #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_data_out,
  input logic [8:0]  out_entry_count
);

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ssit_pkg::ST_OK || out_status == ssit_pkg::ST_ABSENT ||
                   out_status == ssit_pkg::ST_FULL))
    else $error("undefined status code");

  // a failed request never returns a value
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ssit_pkg::ST_OK) |-> (out_data_out == '0))
    else $error("nonzero data on failed request");

  // a full report only comes from a full table
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ssit_pkg::ST_FULL) |-> (out_entry_count == 9'(TABLE_DEPTH)))
    else $error("full status with table not full");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
                                   $stable(out_data_out) && $stable(out_entry_count)))
    else $error("result beat changed while stalled");

endmodule

bind sorted_sparse_index_table_top ssit_chk #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_ssit_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_data_out    (out_data_out),
  .out_entry_count (out_entry_count)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench for the sorted sparse index table: scoreboard with its own sorted table, driver tasks
module tb;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned END_DRAIN   = 300;
  localparam int unsigned HOLD_CYCLES = 400;

  // sorted key/value table kept alongside the block, plus the queue of awaited results
  class index_table_scoreboard;
    logic [31:0] key_mem [TABLE_DEPTH];
    logic [31:0] val_mem [TABLE_DEPTH];
    int unsigned stored = 0;
    int unsigned peak_stored = 0;
    ssit_pkg::res_t awaited [$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned absent_seen = 0;
    int unsigned full_seen = 0;

    // first slot whose key is not below k
    function int unsigned find_slot(logic [31:0] k);
      int unsigned first, span, half;
      first = 0;
      span = stored;
      while (span != 0) begin
        half = span / 2;
        if (key_mem[first + half] < k) begin
          first = first + half + 1;
          span = span - half - 1;
        end else begin
          span = half;
        end
      end
      return first;
    endfunction

    // apply an accepted request to the table and queue its result
    function void note_request(ssit_pkg::op_t op, logic [31:0] idx, logic [31:0] value);
      int unsigned slot, i;
      bit hit;
      ssit_pkg::res_t r;
      slot = find_slot(idx);
      hit = (slot < stored) && (key_mem[slot] == idx);
      r.status = ssit_pkg::ST_OK;
      r.data_out = '0;
      case (op)
        ssit_pkg::OP_GET: begin
          if (hit) r.data_out = val_mem[slot];
          else r.status = ssit_pkg::ST_ABSENT;
        end
        ssit_pkg::OP_SET: begin
          if (hit) begin
            val_mem[slot] = value;
          end else if (stored >= TABLE_DEPTH) begin
            r.status = ssit_pkg::ST_FULL;
          end else begin
            // open a hole at the slot
            for (i = stored; i > slot; i--) begin
              key_mem[i] = key_mem[i-1];
              val_mem[i] = val_mem[i-1];
            end
            key_mem[slot] = idx;
            val_mem[slot] = value;
            stored++;
          end
        end
        ssit_pkg::OP_UNSET: begin
          if (hit) begin
            stored--;
            // close the gap left by the removed pair
            for (i = slot; i < stored; i++) begin
              key_mem[i] = key_mem[i+1];
              val_mem[i] = val_mem[i+1];
            end
          end else begin
            r.status = ssit_pkg::ST_ABSENT;
          end
        end
        default: stored = 0;
      endcase
      if (stored > peak_stored) peak_stored = stored;
      r.entry_count = ssit_pkg::COUNT_OUT_W'(stored);
      awaited.push_back(r);
    endfunction

    // compare one result beat with the oldest awaited result
    function void check_result(logic [1:0] st, logic [31:0] d, logic [8:0] cnt);
      ssit_pkg::res_t want;
      results_seen++;
      if (st == ssit_pkg::ST_ABSENT) absent_seen++;
      if (st == ssit_pkg::ST_FULL) full_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected result beat: status %0d data %h count %0d", st, d, cnt);
        return;
      end
      want = awaited.pop_front();
      if (want.status !== st || want.data_out !== d || want.entry_count !== cnt) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: result %0d wrong: expected status %0d data %h count %0d, got %0d %h %0d",
                   results_seen, want.status, want.data_out, want.entry_count, st, d, cnt);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = ssit_pkg::OP_GET;
  logic [31:0] in_index = '0;
  logic [31:0] in_data_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_data_out;
  logic [8:0]  out_entry_count;

  index_table_scoreboard table_sb;
  bit          idle_on = 1'b1;
  bit          long_hold = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned sent = 0;
  logic [31:0] key_pool [$];

  sorted_sparse_index_table_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_index        (in_index),
    .in_data_in      (in_data_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_entry_count (out_entry_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: timeout after %0d cycles", cycle_count);
    $display("tb: FAIL");
    $finish;
  end

  // offer one request beat and wait for it to be taken
  task automatic send_request(ssit_pkg::op_t op, logic [31:0] idx, logic [31:0] value);
    if (idle_on && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_index   <= idx;
    in_data_in <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    table_sb.note_request(op, idx, value);
    sent++;
  endtask

  // key pool with the extremes and runs of adjacent keys
  task automatic build_pool(int unsigned n);
    key_pool.delete();
    key_pool.push_back(32'h0000_0000);
    key_pool.push_back(32'hFFFF_FFFF);
    while (key_pool.size() < n) begin
      if ($urandom_range(0, 3) == 0) key_pool.push_back(key_pool[key_pool.size()-1] + 1);
      else key_pool.push_back($urandom);
    end
  endtask

  // random gets, sets, unsets and clears over the pool, a few stray keys
  task automatic run_mixed(int unsigned n, int unsigned clear_pct);
    int unsigned pick;
    logic [31:0] k;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) k = $urandom;
      else k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (pick < clear_pct) send_request(ssit_pkg::OP_CLEAR, $urandom, $urandom);
      else if (pick < 35) send_request(ssit_pkg::OP_GET, k, $urandom);
      else if (pick < 75) send_request(ssit_pkg::OP_SET, k, $urandom);
      else send_request(ssit_pkg::OP_UNSET, k, $urandom);
    end
  endtask

  // a key known to be stored right now
  function automatic logic [31:0] stored_key();
    return table_sb.key_mem[$urandom_range(0, table_sb.stored - 1)];
  endfunction

  // fill the table, then work it while full
  task automatic run_full_table();
    logic [31:0] k;
    send_request(ssit_pkg::OP_CLEAR, '0, '0);
    while (table_sb.stored < TABLE_DEPTH) send_request(ssit_pkg::OP_SET, $urandom, $urandom);
    repeat (8) send_request(ssit_pkg::OP_SET, $urandom, $urandom);
    repeat (8) send_request(ssit_pkg::OP_SET, stored_key(), $urandom);
    repeat (8) send_request(ssit_pkg::OP_GET, stored_key(), '0);
    repeat (4) send_request(ssit_pkg::OP_GET, $urandom, '0);
    // churn at the top of the table
    repeat (12) begin
      send_request(ssit_pkg::OP_UNSET, stored_key(), $urandom);
      k = $urandom;
      send_request(ssit_pkg::OP_SET, k, $urandom);
      send_request(ssit_pkg::OP_GET, k, '0);
    end
    send_request(ssit_pkg::OP_SET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ssit_pkg::OP_SET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(ssit_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // result side: check beats, random back-pressure, one long hold-off on request
  initial begin : result_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        table_sb.check_result(out_status, out_data_out, out_entry_count);
      if (long_hold) begin
        long_hold = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_on && $urandom_range(0, 99) < 11);
      end
    end
  end

  // stimulus
  initial begin
    table_sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, overwrite, removes at both ends
    send_request(ssit_pkg::OP_GET,   32'h0000_0000, 32'h0);
    send_request(ssit_pkg::OP_UNSET, 32'h0000_0005, 32'h0);
    send_request(ssit_pkg::OP_CLEAR, 32'h0000_0000, 32'h0);
    send_request(ssit_pkg::OP_SET,   32'h8000_0000, 32'hFFFF_FFFF);
    send_request(ssit_pkg::OP_SET,   32'h0000_0000, 32'h0000_0000);
    send_request(ssit_pkg::OP_SET,   32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_request(ssit_pkg::OP_SET,   32'h7FFF_FFFF, 32'h5A5A_5A5A);
    send_request(ssit_pkg::OP_GET,   32'h0000_0000, 32'h0);
    send_request(ssit_pkg::OP_GET,   32'hFFFF_FFFF, 32'h0);
    send_request(ssit_pkg::OP_GET,   32'h8000_0000, 32'h0);
    send_request(ssit_pkg::OP_GET,   32'h8000_0001, 32'h0);
    send_request(ssit_pkg::OP_SET,   32'h8000_0000, 32'h1234_5678);
    send_request(ssit_pkg::OP_GET,   32'h8000_0000, 32'h0);
    send_request(ssit_pkg::OP_UNSET, 32'h7FFF_FFFF, 32'h0);
    send_request(ssit_pkg::OP_UNSET, 32'h7FFF_FFFF, 32'h0);
    send_request(ssit_pkg::OP_GET,   32'h7FFF_FFFF, 32'h0);
    send_request(ssit_pkg::OP_UNSET, 32'h0000_0000, 32'h0);
    send_request(ssit_pkg::OP_UNSET, 32'hFFFF_FFFF, 32'h0);
    send_request(ssit_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ssit_pkg::OP_GET,   32'h8000_0000, 32'h0);
    send_request(ssit_pkg::OP_SET,   32'h0000_0001, 32'h0000_0001);
    send_request(ssit_pkg::OP_UNSET, 32'h0000_0001, 32'h0);

    // small pool with idling, long receiver hold-off part way through
    build_pool(48);
    run_mixed(200, 2);
    long_hold = 1'b1;
    run_mixed(400, 2);

    // same mix with no idling on either side
    idle_on = 1'b0;
    build_pool(48);
    run_mixed(400, 2);
    idle_on = 1'b1;

    run_full_table();

    // larger pool, rare clears, so the table grows deep
    build_pool(160);
    run_mixed(600, 1);

    // drop valid right at the last accepting edge
    in_valid <= 1'b0;
    @(posedge clk);
    while (table_sb.awaited.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);

    $display("tb: %0d requests, %0d results checked (%0d not present, %0d table full)",
             sent, table_sb.results_seen, table_sb.absent_seen, table_sb.full_seen);
    $display("tb: table reached %0d of %0d entries, %0d mismatches",
             table_sb.peak_stored, TABLE_DEPTH, table_sb.mismatches);
    if (table_sb.mismatches == 0 && table_sb.awaited.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ssit_pkg.sv
hw/rtl/ssit_ram.sv
hw/rtl/ssit_ctrl.sv
hw/rtl/sorted_sparse_index_table_top.sv
hw/rtl/ssit_chk.sv
tb/tb.sv
